FILE: hdl/lbbc_pkg.sv
// ----------------------------------------------------------------------------
// lbbc_pkg: shared types and constants of the leaky-bucket buffer check
// Field widths, refill arithmetic constants, register indexes and the
// per-segment side data that travels alongside the refill pipeline.
// ----------------------------------------------------------------------------
package lbbc_pkg;

  // field widths
  localparam int TS_W    = 32;
  localparam int LEN_W   = 16;
  localparam int RATE_W  = 26;
  localparam int SIZE_W  = 25;
  localparam int LEVEL_W = 32;

  // segment cost is payload plus fixed header bytes
  localparam int SEG_OVERHEAD = 11;
  localparam int COST_W       = LEN_W + 1;

  // refill arithmetic: ticks * rate / 90000, rounded half to even
  localparam int TICKS_PER_S = 90000;
  localparam int HALF_TICKS  = TICKS_PER_S / 2;
  localparam int REM_W       = 17;
  localparam int PROD_W      = TS_W + RATE_W;
  localparam int REFILL_W    = 34;
  localparam int SUM_W       = REFILL_W + 1;

  // refill division: 16-bit quotient digits, each by reciprocal multiplication
  localparam int CHUNK_W     = 16;
  localparam int NCHUNK      = (PROD_W + CHUNK_W - 1) / CHUNK_W;
  localparam int QUO_W       = NCHUNK * CHUNK_W;
  localparam int X_W         = REM_W + CHUNK_W;
  localparam int RECIP_W     = 34;
  localparam int RECIP_SHIFT = 50;
  localparam int SCALED_W    = X_W + RECIP_W;
  // ceil(2^50 / 90000), exact for every digit dividend below 2^33
  localparam logic [RECIP_W-1:0] RECIP_M = 34'd12509998965;

  // configuration port
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = RATE_W;
  localparam logic [CFG_IDX_W-1:0] REG_BITRATE     = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_BUFFER_SIZE = 1'b1;

  localparam int BITRATE_RESET     = 0;
  localparam int BUFFER_SIZE_RESET = 1048576;

  // side data of one segment
  typedef struct packed {
    logic [COST_W-1:0] cost;
    logic              set_start;
    logic              set_end;
    logic              first;
  } seg_side_t;

endpackage

FILE: hdl/lbbc_refill.sv
// ----------------------------------------------------------------------------
// lbbc_refill: refill byte count pipeline
// Multiplies elapsed ticks by the bitrate, divides by the tick rate one
// 16-bit quotient digit at a time by reciprocal multiplication, rounds half
// to even and saturates. Segment side data rides along; stages collapse
// bubbles.
// ----------------------------------------------------------------------------
module lbbc_refill
  import lbbc_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [TS_W-1:0]     ticks,
  input  logic [RATE_W-1:0]   rate,
  input  seg_side_t           in_side,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [REFILL_W-1:0] refill,
  output seg_side_t           out_side
);

  // ticks, product, two stages per quotient digit, rounding
  localparam int NST        = 2 * NCHUNK + 3;
  localparam int ST_PROD    = 1;
  localparam int ST_DIV0    = 2;

  localparam logic [X_W-1:0]      DIVISOR    = X_W'(TICKS_PER_S);
  localparam logic [REM_W-1:0]    HALF       = REM_W'(HALF_TICKS);
  localparam logic [REFILL_W-1:0] REFILL_SAT = {1'b1, {(REFILL_W - 1){1'b0}}};

  logic [NST-1:0]      vld;
  logic [NST:0]        rdy;
  seg_side_t           side_q [NST];
  logic [TS_W-1:0]     ticks_q;
  logic [PROD_W-1:0]   prod_q;
  logic [X_W-1:0]      xa_q [NCHUNK];
  logic [QUO_W-1:0]    pa_q [NCHUNK];
  logic [QUO_W-1:0]    pb_q [NCHUNK];
  logic [REM_W-1:0]    rb_q [NCHUNK];
  logic [REFILL_W-1:0] refill_q;
  logic [REFILL_W-1:0] refill_next;
  logic [PROD_W-1:0]   prod_next;

  // a stage takes a transfer when empty or when its content moves on
  always_comb begin
    rdy[NST] = out_ready;
    for (int k = NST - 1; k >= 0; k--) begin
      rdy[k] = !vld[k] || rdy[k + 1];
    end
  end

  assign in_ready = rdy[0];

  // stage valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (rdy[0]) vld[0] <= in_valid;
      for (int k = 1; k < NST; k++) begin
        if (rdy[k]) vld[k] <= vld[k - 1];
      end
    end
  end

  // side data follows its segment
  always_ff @(posedge clk) begin
    if (rdy[0]) side_q[0] <= in_side;
    for (int k = 1; k < NST; k++) begin
      if (rdy[k]) side_q[k] <= side_q[k - 1];
    end
  end

  // ticks register and product
  assign prod_next = PROD_W'(ticks_q) * PROD_W'(rate);

  always_ff @(posedge clk) begin
    if (rdy[0]) ticks_q <= ticks;
    if (rdy[ST_PROD]) prod_q <= prod_next;
  end

  // division by the tick rate, one 16-bit quotient digit per stage pair
  for (genvar j = 0; j < NCHUNK; j++) begin : g_div
    logic [QUO_W-1:0]    pd_in;
    logic [REM_W-1:0]    rem_in;
    logic [X_W-1:0]      x;
    logic [SCALED_W-1:0] x_scaled;
    logic [CHUNK_W-1:0]  digit;
    logic [X_W-1:0]      back;
    logic [X_W-1:0]      diff;

    if (j == 0) begin : g_first
      assign pd_in  = QUO_W'(prod_q);
      assign rem_in = '0;
    end else begin : g_next
      assign pd_in  = pb_q[j - 1];
      assign rem_in = rb_q[j - 1];
    end

    // digit estimate by the reciprocal, exact for this dividend range
    assign x        = {rem_in, pd_in[QUO_W-1 -: CHUNK_W]};
    assign x_scaled = SCALED_W'(x) * SCALED_W'(RECIP_M);
    assign digit    = x_scaled[RECIP_SHIFT +: CHUNK_W];

    // dividend bits shift out at the top, quotient digits in at the bottom
    always_ff @(posedge clk) begin
      if (rdy[ST_DIV0 + 2 * j]) begin
        xa_q[j] <= x;
        pa_q[j] <= {pd_in[QUO_W-CHUNK_W-1:0], digit};
      end
    end

    // remainder of this digit
    assign back = X_W'(pa_q[j][CHUNK_W-1:0]) * DIVISOR;
    assign diff = xa_q[j] - back;

    always_ff @(posedge clk) begin
      if (rdy[ST_DIV0 + 2 * j + 1]) begin
        pb_q[j] <= pa_q[j];
        rb_q[j] <= diff[REM_W-1:0];
      end
    end
  end

  // round half to even, saturate far above any reachable capacity
  always_comb begin : p_round
    logic [QUO_W-1:0] q;
    logic [REM_W-1:0] r;
    logic             inc;
    q   = pb_q[NCHUNK-1];
    r   = rb_q[NCHUNK-1];
    inc = (r > HALF) || ((r == HALF) && q[0]);
    if (|q[QUO_W-1:REFILL_W-1]) begin
      refill_next = REFILL_SAT;
    end else begin
      refill_next = {1'b0, q[REFILL_W-2:0]} + REFILL_W'(inc);
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[NST-1]) refill_q <= refill_next;
  end

  assign out_valid = vld[NST-1];
  assign refill    = refill_q;
  assign out_side  = side_q[NST-1];

endmodule

FILE: hdl/leaky_bucket_buffer_check.sv
// ----------------------------------------------------------------------------
// leaky_bucket_buffer_check: subtitle segment receive buffer check
// Refills a leaky-bucket level by the decode time gap times the bitrate,
// caps it at the buffer size (a first segment starts full), drains each segment's cost and flags
// underflow per display set.
//
//   channel   signals                                        direction
//   input     in_valid/in_ready, decode_ts, payload_len,     in
//             set_start, set_end, first_segment
//   result    out_valid/out_ready, fill_level, segment_ok,   out
//             set_good, underflow_at_end
//   config    cfg_we, cfg_index, cfg_data                    in
//
// One segment per cycle sustained while results are taken; a segment passes
// from its input transfer through the ticks register, product, four quotient
// digits of two stages each and rounding, then the result register where the
// level loop closes. Reset clears level and previous timestamp and sets the
// set flag; each stage holds its segment while the one after it stalls.
// ----------------------------------------------------------------------------
module leaky_bucket_buffer_check
  import lbbc_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_we,
  input  logic [CFG_IDX_W-1:0]      cfg_index,
  input  logic [CFG_DATA_W-1:0]     cfg_data,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic [TS_W-1:0]           decode_ts,
  input  logic [LEN_W-1:0]          payload_len,
  input  logic                      set_start,
  input  logic                      set_end,
  input  logic                      first_segment,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic signed [LEVEL_W-1:0] fill_level,
  output logic                      segment_ok,
  output logic                      set_good,
  output logic                      underflow_at_end
);

  localparam logic signed [SUM_W-1:0] LEVEL_FLOOR =
    {{(SUM_W - LEVEL_W + 1){1'b1}}, {(LEVEL_W - 1){1'b0}}};

  logic [RATE_W-1:0]         bitrate;
  logic [SIZE_W-1:0]         buffer_size;
  logic [TS_W-1:0]           previous_ts;
  logic signed [LEVEL_W-1:0] level;
  logic                      set_good_flag;

  logic [TS_W-1:0]           elapsed;
  seg_side_t                 in_side;
  logic                      rf_valid;
  logic                      rf_ready;
  logic [REFILL_W-1:0]       rf_refill;
  seg_side_t                 rf_side;
  logic                      load;

  logic signed [SUM_W-1:0]   sum;
  logic signed [SUM_W-1:0]   cap;
  logic signed [SUM_W-1:0]   capped;
  logic signed [SUM_W-1:0]   drained;
  logic signed [LEVEL_W-1:0] level_next;
  logic                      neg;
  logic                      set_good_next;

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      bitrate     <= RATE_W'(BITRATE_RESET);
      buffer_size <= SIZE_W'(BUFFER_SIZE_RESET);
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_BITRATE:     bitrate     <= cfg_data[RATE_W-1:0];
        REG_BUFFER_SIZE: buffer_size <= cfg_data[SIZE_W-1:0];
        default:         ;
      endcase
    end
  end

  // elapsed ticks against the previous transfer, wrapping
  assign elapsed = decode_ts - previous_ts;

  always_ff @(posedge clk) begin
    if (rst) begin
      previous_ts <= '0;
    end else if (in_valid && in_ready) begin
      previous_ts <= decode_ts;
    end
  end

  assign in_side.cost      = COST_W'(payload_len) + COST_W'(SEG_OVERHEAD);
  assign in_side.set_start = set_start;
  assign in_side.set_end   = set_end;
  assign in_side.first     = first_segment;

  lbbc_refill u_refill (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .ticks     (elapsed),
    .rate      (bitrate),
    .in_side   (in_side),
    .out_valid (rf_valid),
    .out_ready (rf_ready),
    .refill    (rf_refill),
    .out_side  (rf_side)
  );

  // output register takes a transfer when empty or being drained
  assign rf_ready = !out_valid || out_ready;
  assign load     = rf_valid && rf_ready;

  // level update: refill, cap, drain, saturate at the negative bound
  always_comb begin
    sum     = SUM_W'(level) + $signed({1'b0, rf_refill});
    cap     = $signed(SUM_W'(buffer_size));
    if (rf_side.first) begin
      capped = cap;
    end else if (sum > cap) begin
      capped = cap;
    end else begin
      capped = sum;
    end
    drained = capped - $signed(SUM_W'(rf_side.cost));
    if (drained < LEVEL_FLOOR) begin
      level_next = LEVEL_FLOOR[LEVEL_W-1:0];
    end else begin
      level_next = drained[LEVEL_W-1:0];
    end
    neg           = level_next[LEVEL_W-1];
    set_good_next = (rf_side.set_start || set_good_flag) && !neg;
  end

  // stream state
  always_ff @(posedge clk) begin
    if (rst) begin
      level         <= '0;
      set_good_flag <= 1'b1;
    end else if (load) begin
      level         <= level_next;
      set_good_flag <= set_good_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      fill_level       <= level_next;
      segment_ok       <= !neg;
      set_good         <= set_good_next;
      underflow_at_end <= rf_side.set_end && !set_good_next;
    end
  end

endmodule
